// ----- rtl/frp_pkg.sv -----
// ============================================================================
// frp_pkg
// Shared types, constants and a decode helper for the FASTA record parser.
// ============================================================================
`default_nettype none

package frp_pkg;

    // Parameter defaults
    localparam int LINE_MAX_DEF    = 1024;
    localparam int MAX_NAME_DEF    = 256;
    localparam int LENGTH_BITS_DEF = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_NAME_OFFSET = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT_ONLY  = 1'd1;

    localparam logic [7:0] NAME_OFFSET_RST = 8'd1;
    localparam logic       COUNT_ONLY_RST  = 1'b0;

    // Special bytes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PIPE  = 8'h7C;

    // Base codes
    localparam logic [3:0] BASE_T   = 4'd0;
    localparam logic [3:0] BASE_C   = 4'd1;
    localparam logic [3:0] BASE_A   = 4'd2;
    localparam logic [3:0] BASE_G   = 4'd3;
    localparam logic [3:0] BASE_AMB = 4'd10;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SEEK = 3'd0,
        PH_SCAN = 3'd1,
        PH_SKIP = 3'd2,
        PH_SEQ  = 3'd3,
        PH_BAD  = 3'd4
    } phase_t;

    // Result kind
    typedef enum logic [2:0] {
        K_NAME = 3'd0,
        K_BASE = 3'd1,
        K_DONE = 3'd2,
        K_ERR  = 3'd3,
        K_NONE = 3'd4
    } kind_t;

    // Input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    // Result item
    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  name_char;
        logic [3:0]  base_code;
        logic [31:0] record_length;
        logic        empty_record;
    } out_item_t;

    // Nucleotide decode result
    typedef struct packed {
        logic       valid;
        logic [3:0] code;
    } base_dec_t;

    // Map a byte to its base code, either case
    function automatic base_dec_t base_of(input logic [7:0] b);
        logic [7:0] c;
        base_dec_t  r;
        c = b;
        if (b >= "A" && b <= "Z") begin
            c = b | 8'h20;
        end
        r.valid = 1'b1;
        r.code  = BASE_AMB;
        case (c)
            "t", "u": r.code = BASE_T;
            "c":      r.code = BASE_C;
            "a":      r.code = BASE_A;
            "g":      r.code = BASE_G;
            "y", "r", "s", "w", "k", "m", "b",
            "d", "h", "i", "q", "v", "x", "n": r.code = BASE_AMB;
            default: begin
                r.valid = 1'b0;
                r.code  = 4'd0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/frp_in_stage.sv -----
// ============================================================================
// frp_in_stage
// Input register: holds one byte item until the parse step consumes it.
// ============================================================================
`default_nettype none

module frp_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire frp_pkg::in_item_t s_data,
    input  wire logic              advance,
    output logic                   item_valid,
    output frp_pkg::in_item_t      item_data
);
    import frp_pkg::*;

    logic     run_reg;
    logic     valid_reg, valid_next;
    in_item_t data_reg, data_next;
    logic     take;

    // Ready once out of reset and the register is empty or its item leaves this cycle
    assign s_ready = run_reg && (!valid_reg || advance);
    assign take    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (take) begin
            valid_next = 1'b1;
            data_next  = s_data;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            run_reg   <= 1'b1;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/frp_core.sv -----
// ============================================================================
// frp_core
// Parse state, configuration registers and per-byte result decode.
// ============================================================================
`default_nettype none

module frp_core #(
    parameter int LINE_MAX    = frp_pkg::LINE_MAX_DEF,
    parameter int MAX_NAME    = frp_pkg::MAX_NAME_DEF,
    parameter int LENGTH_BITS = frp_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [frp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [frp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               item_valid,
    input  wire frp_pkg::in_item_t                  item_data,
    input  wire logic                               advance,
    output logic                                    res_valid,
    output frp_pkg::out_item_t                      res_data
);
    import frp_pkg::*;

    localparam logic [15:0] POS_LIMIT  = 16'(LINE_MAX - 1);
    localparam logic [8:0]  NAME_LIMIT = 9'(MAX_NAME);

    // Configuration
    logic [7:0] name_offset_reg;
    logic       count_only_reg;

    // Parse state
    phase_t                 phase_reg, phase_next;
    logic [15:0]            line_pos_reg, line_pos_next;
    logic                   started_reg, started_next;
    logic [8:0]             name_cnt_reg, name_cnt_next;
    logic [LENGTH_BITS-1:0] base_cnt_reg, base_cnt_next;

    logic       step;
    logic [7:0] b;
    logic       eoi;
    logic       is_nl, is_gt, is_colon, is_delim;
    logic       in_record;
    base_dec_t  base_dec;

    // Header scan decode
    logic        from_seek;
    logic [15:0] scan_pos, scan_pos_inc;
    logic        scan_started;
    logic [8:0]  scan_count;
    logic        scan_limit, scan_before, scan_name, scan_emit, scan_stop;
    logic        scan_go;

    assign step      = item_valid && advance;
    assign b         = item_data.data_byte;
    assign eoi       = item_data.end_of_input;
    assign is_nl     = (b == CH_NL);
    assign is_gt     = (b == CH_GT);
    assign is_colon  = (b == CH_COLON);
    assign is_delim  = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_PIPE);
    assign base_dec  = base_of(b);
    assign in_record = (phase_reg == PH_SCAN) || (phase_reg == PH_SKIP)
                       || (phase_reg == PH_SEQ);

    // A '>' while seeking opens a header at position zero
    always_comb begin
        from_seek    = (phase_reg == PH_SEEK);
        scan_pos     = from_seek ? 16'd0 : line_pos_reg;
        scan_started = from_seek ? 1'b0 : started_reg;
        scan_count   = from_seek ? 9'd0 : name_cnt_reg;
        scan_pos_inc = (scan_pos == 16'hFFFF) ? scan_pos : scan_pos + 16'd1;
        scan_limit   = (scan_pos >= POS_LIMIT);
        scan_before  = (scan_pos < {8'd0, name_offset_reg});
        scan_name    = !is_nl && !scan_limit && !scan_before && !is_colon && !is_delim;
        scan_emit    = scan_name && (scan_count < NAME_LIMIT);
        scan_stop    = !is_nl && (scan_limit
                       || (!scan_before && (is_colon || (is_delim && scan_started))));
        scan_go      = !eoi && ((phase_reg == PH_SCAN) || (from_seek && is_gt));
    end

    // Next state
    always_comb begin
        phase_next    = phase_reg;
        line_pos_next = line_pos_reg;
        started_next  = started_reg;
        name_cnt_next = name_cnt_reg;
        base_cnt_next = base_cnt_reg;
        if (eoi) begin
            phase_next    = PH_SEEK;
            line_pos_next = 16'd0;
            if (in_record) begin
                base_cnt_next = '0;
            end
        end else begin
            unique case (phase_reg)
                PH_SCAN: begin
                    // handled by the scan update below
                end
                PH_SKIP: begin
                    if (is_nl) begin
                        phase_next    = PH_SEQ;
                        base_cnt_next = '0;
                    end
                end
                PH_SEQ: begin
                    if (is_gt) begin
                        phase_next    = PH_SCAN;
                        line_pos_next = 16'd1;
                        started_next  = 1'b0;
                        name_cnt_next = 9'd0;
                        base_cnt_next = '0;
                    end else if (base_dec.valid && (base_cnt_reg != '1)) begin
                        base_cnt_next = base_cnt_reg + LENGTH_BITS'(1);
                    end
                end
                PH_BAD: begin
                    if (is_nl) begin
                        phase_next = PH_SEEK;
                    end
                end
                default: begin
                    phase_next = PH_SEEK;
                    if (is_gt) begin
                        base_cnt_next = '0;
                    end else if (!is_nl) begin
                        phase_next = PH_BAD;
                    end
                end
            endcase
        end
        // Header scan update
        if (scan_go) begin
            line_pos_next = scan_pos_inc;
            started_next  = scan_started || scan_name;
            name_cnt_next = scan_count + {8'd0, scan_emit};
            if (is_nl) begin
                phase_next    = PH_SEQ;
                base_cnt_next = '0;
            end else if (scan_stop) begin
                phase_next = PH_SKIP;
            end else begin
                phase_next = PH_SCAN;
            end
        end
    end

    // Result of the current byte
    always_comb begin
        res_valid = 1'b0;
        res_data  = '0;
        if (eoi) begin
            res_valid = 1'b1;
            if (in_record) begin
                res_data.result_kind   = K_DONE;
                res_data.record_length = 32'(base_cnt_reg);
                res_data.empty_record  = (base_cnt_reg == '0);
            end else begin
                res_data.result_kind = K_NONE;
            end
        end else begin
            unique case (phase_reg)
                PH_SCAN: begin
                    if (scan_emit) begin
                        res_valid          = 1'b1;
                        res_data.result_kind = K_NAME;
                        res_data.name_char = b;
                    end
                end
                PH_SEQ: begin
                    if (is_gt) begin
                        res_valid              = 1'b1;
                        res_data.result_kind   = K_DONE;
                        res_data.record_length = 32'(base_cnt_reg);
                        res_data.empty_record  = (base_cnt_reg == '0);
                    end else if (base_dec.valid && !count_only_reg) begin
                        res_valid            = 1'b1;
                        res_data.result_kind = K_BASE;
                        res_data.base_code   = base_dec.code;
                    end
                end
                PH_SKIP, PH_BAD: begin
                    res_valid = 1'b0;
                end
                default: begin
                    if (is_gt) begin
                        if (scan_emit) begin
                            res_valid            = 1'b1;
                            res_data.result_kind = K_NAME;
                            res_data.name_char   = b;
                        end
                    end else if (!is_nl) begin
                        res_valid            = 1'b1;
                        res_data.result_kind = K_ERR;
                    end
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_offset_reg <= NAME_OFFSET_RST;
            count_only_reg  <= COUNT_ONLY_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NAME_OFFSET: name_offset_reg <= cfg_wdata;
                REG_COUNT_ONLY:  count_only_reg  <= cfg_wdata[0];
                default: begin
                    name_offset_reg <= name_offset_reg;
                end
            endcase
        end
    end

    // Parse state registers advance once per consumed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SEEK;
            line_pos_reg <= 16'd0;
            started_reg  <= 1'b0;
            name_cnt_reg <= 9'd0;
            base_cnt_reg <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            line_pos_reg <= line_pos_next;
            started_reg  <= started_next;
            name_cnt_reg <= name_cnt_next;
            base_cnt_reg <= base_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/frp_out_stage.sv -----
// ============================================================================
// frp_out_stage
// Result register: holds one result until the receiver takes it.
// ============================================================================
`default_nettype none

module frp_out_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               item_valid,
    input  wire logic               res_valid,
    input  wire frp_pkg::out_item_t res_data,
    output logic                    advance,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output frp_pkg::out_item_t      m_data
);
    import frp_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t data_reg, data_next;

    // Register is free when empty or its transfer completes now
    assign advance = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (advance) begin
            valid_next = item_valid && res_valid;
            data_next  = res_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/fasta_record_parser.sv -----
// ============================================================================
// fasta_record_parser
// FASTA byte-stream parser: record names, base codes and record lengths.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one byte item per transfer (data byte and an
//   end-of-input flag). m_valid/m_ready/m_data carry zero or one result per
//   byte: a name character, a base code, record done with its length, a
//   format error, or "no record before end".
//   cfg_wr_en/cfg_index/cfg_wdata write name_offset (index 0) and count_only
//   (index 1); write only while the parser is idle.
// Path: a byte is held in the input register, and its result is then loaded
//   into the result register from that registered byte.
// Throughput: one byte per cycle while not stalled; each byte's parse step
//   is a single decode stage between the input and result registers.
// Reset: aresetn low clears the parse state to header seek and loads the
//   register defaults; s_ready rises in the cycle after reset is released.
// Stall: while m_ready is low the result register holds, the input register
//   fills, and s_ready drops; nothing is lost or repeated.
// ============================================================================
`default_nettype none

module fasta_record_parser #(
    parameter int LINE_MAX    = frp_pkg::LINE_MAX_DEF,
    parameter int MAX_NAME    = frp_pkg::MAX_NAME_DEF,
    parameter int LENGTH_BITS = frp_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [frp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [frp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire frp_pkg::in_item_t                  s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output frp_pkg::out_item_t                      m_data
);
    import frp_pkg::*;

    logic      advance;
    logic      item_valid;
    in_item_t  item_data;
    logic      res_valid;
    out_item_t res_data;

    frp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item_data  (item_data)
    );

    frp_core #(
        .LINE_MAX    (LINE_MAX),
        .MAX_NAME    (MAX_NAME),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_data  (item_data),
        .advance    (advance),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    frp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

// ----- rtl/frp_checker.sv -----
// ============================================================================
// frp_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ============================================================================
`default_nettype none

module frp_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire frp_pkg::out_item_t m_data
);
    import frp_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Empty flag agrees with the length on record done
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.result_kind == K_DONE)
        |-> (m_data.empty_record == (m_data.record_length == 32'd0)))
        else $error("empty flag disagrees with length");

    // Length fields are zero on other kinds
    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.result_kind != K_DONE)
        |-> (m_data.record_length == 32'd0) && !m_data.empty_record)
        else $error("length set on non-done result");

    // Base codes stay in the code set
    a_base: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.result_kind == K_BASE)
        |-> (m_data.base_code <= BASE_G) || (m_data.base_code == BASE_AMB))
        else $error("base code out of range");

endmodule

bind fasta_record_parser frp_checker u_frp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ----- tb/sv/frp_result_checker.sv -----
// ----------------------------------------------------------------------------
// FASTA record parser result checker
// Watches the byte and result channels of the parser. It predicts each
// accepted byte's result from its own copy of the parse state and compares
// every result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module frp_result_checker
    import frp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_item_t               s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_item_t              m_data,
    output int                     outstanding,
    output int                     mismatches
);

    localparam logic [63:0] LEN_SAT = (64'd1 << LENGTH_BITS_DEF) - 64'd1;

    // shadow registers and parse state
    logic [7:0]  offset_reg;
    logic        count_only_reg;
    phase_t      parse_phase;
    logic [15:0] line_pos;
    logic        name_seen;
    logic [8:0]  name_len;
    logic [31:0] bases;

    out_item_t   pending_results[$];

    // nucleotide letter to base code, either case; returns 0 when not a base
    function automatic bit decode_base(input logic [7:0] b, output logic [3:0] code);
        logic [7:0] c;
        c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        code = BASE_AMB;
        case (c)
            "t", "u": code = BASE_T;
            "c":      code = BASE_C;
            "a":      code = BASE_A;
            "g":      code = BASE_G;
            "y", "r", "s", "w", "k", "m", "b",
            "d", "h", "i", "q", "v", "x", "n": code = BASE_AMB;
            default:  return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic out_item_t record_done();
        out_item_t r;
        r = '0;
        r.result_kind   = K_DONE;
        r.record_length = bases;
        r.empty_record  = (bases == 32'd0);
        return r;
    endfunction

    function automatic void open_header(input logic [15:0] pos);
        parse_phase = PH_SCAN;
        line_pos    = pos;
        name_seen   = 1'b0;
        name_len    = '0;
        bases       = '0;
    endfunction

    // one header byte while the name is being scanned
    function automatic bit scan_header_byte(input logic [7:0] b, inout out_item_t res);
        logic [15:0] pos;
        pos = line_pos;
        if (line_pos != 16'hFFFF) line_pos = line_pos + 16'd1;
        if (b == CH_NL) begin
            parse_phase = PH_SEQ;
            bases = '0;
            return 1'b0;
        end
        // past the line buffer: drop the rest of the line
        if (int'(pos) >= LINE_MAX_DEF - 1) begin
            parse_phase = PH_SKIP;
            return 1'b0;
        end
        if (pos < {8'd0, offset_reg}) return 1'b0;
        if (b == CH_COLON) begin
            parse_phase = PH_SKIP;
        end else if (b == CH_SPACE || b == CH_TAB || b == CH_PIPE) begin
            if (name_seen) parse_phase = PH_SKIP;
        end else begin
            name_seen = 1'b1;
            if (int'(name_len) < MAX_NAME_DEF) begin
                name_len = name_len + 9'd1;
                res.result_kind = K_NAME;
                res.name_char   = b;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // advance the parse state by one byte; 1 when the byte gives a result
    function automatic bit parse_byte(input in_item_t item, output out_item_t res);
        phase_t     was;
        logic [3:0] code;
        res = '0;
        if (item.end_of_input) begin
            was = parse_phase;
            parse_phase = PH_SEEK;
            line_pos = '0;
            if (was == PH_SCAN || was == PH_SKIP || was == PH_SEQ) begin
                res = record_done();
                bases = '0;
            end else begin
                res.result_kind = K_NONE;
            end
            return 1'b1;
        end
        case (parse_phase)
            PH_SCAN: begin
                return scan_header_byte(item.data_byte, res);
            end
            PH_SKIP: begin
                if (item.data_byte == CH_NL) begin
                    parse_phase = PH_SEQ;
                    bases = '0;
                end
                return 1'b0;
            end
            PH_SEQ: begin
                if (item.data_byte == CH_GT) begin
                    res = record_done();
                    open_header(16'd1);
                    return 1'b1;
                end
                if (!decode_base(item.data_byte, code)) return 1'b0;
                if ({32'd0, bases} < LEN_SAT) bases = bases + 32'd1;
                if (count_only_reg) return 1'b0;
                res.result_kind = K_BASE;
                res.base_code   = code;
                return 1'b1;
            end
            PH_BAD: begin
                if (item.data_byte == CH_NL) parse_phase = PH_SEEK;
                return 1'b0;
            end
            default: begin
                // seeking a header: blank lines skipped, anything else but '>' is bad
                parse_phase = PH_SEEK;
                if (item.data_byte == CH_NL) return 1'b0;
                if (item.data_byte == CH_GT) begin
                    open_header(16'd0);
                    return scan_header_byte(item.data_byte, res);
                end
                parse_phase = PH_BAD;
                res.result_kind = K_ERR;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // predict on byte transfers, compare on result transfers
    always @(posedge aclk) begin : monitor
        out_item_t predicted;
        if (!aresetn) begin
            offset_reg     = NAME_OFFSET_RST;
            count_only_reg = COUNT_ONLY_RST;
            parse_phase    = PH_SEEK;
            line_pos       = '0;
            name_seen      = 1'b0;
            name_len       = '0;
            bases          = '0;
            pending_results.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_NAME_OFFSET) offset_reg = cfg_wdata;
                else if (cfg_index == REG_COUNT_ONLY) count_only_reg = cfg_wdata[0];
            end
            if (s_valid && s_ready) begin
                if (parse_byte(s_data, predicted)) pending_results.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transfer, result_kind %0d", m_data.result_kind);
                    mismatches++;
                end else begin
                    predicted = pending_results.pop_front();
                    check_field("result_kind", predicted.result_kind, m_data.result_kind);
                    check_field("name_char", predicted.name_char, m_data.name_char);
                    check_field("base_code", predicted.base_code, m_data.base_code);
                    check_field("record_length", predicted.record_length,
                                m_data.record_length);
                    check_field("empty_record", predicted.empty_record, m_data.empty_record);
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

// ----- tb/sv/tb_fasta_record_parser.sv -----
// ----------------------------------------------------------------------------
// FASTA record parser testbench
// Feeds the parser a directed byte stream covering headers, bases, bad lines
// and end of input, then random FASTA-like streams under several register
// settings and source/sink idling mixes. Checking lives in the result checker.
// ----------------------------------------------------------------------------
module tb_fasta_record_parser;
    import frp_pkg::*;

    typedef enum int {HDR_PLAIN, HDR_LONG_LINE} header_style_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;

    int    pending_count;
    int    check_errors;
    int    src_idle_pct   = 0;
    int    sink_stall_pct = 0;
    int    bytes_sent     = 0;
    string nuc_letters    = "ACGTUNRYSWKMBDHIQVXacgtunryswkmbdhiqvx";

    fasta_record_parser DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    frp_result_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .outstanding (pending_count),
        .mismatches  (check_errors)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result sink stalls at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // hard stop
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // one byte transfer; entered and left at a falling edge
    task automatic send_item(input logic [7:0] b, input logic eoi);
        in_item_t item;
        item.data_byte    = b;
        item.end_of_input = eoi;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) send_item(text[i], 1'b0);
    endtask

    task automatic set_config(input logic [7:0] offset, input logic count_mode);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_NAME_OFFSET;
        cfg_wdata <= offset;
        @(negedge aclk);
        cfg_index <= REG_COUNT_ONLY;
        cfg_wdata <= CFG_DATA_W'(count_mode);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // drain: no byte offered, every result back, then a wait for bytes
    // that give no result
    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [7:0] letter_byte();
        return (8'h41 + 8'($urandom_range(25))) | ($urandom_range(1) ? 8'h20 : 8'h00);
    endfunction

    function automatic logic [7:0] header_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return 8'($urandom_range(126, 33));
        if (pick < 70) return CH_SPACE;
        if (pick < 76) return CH_TAB;
        if (pick < 82) return CH_PIPE;
        if (pick < 86) return CH_COLON;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] sequence_byte();
        if ($urandom_range(99) < 85) return nuc_letters[$urandom_range(nuc_letters.len() - 1)];
        return 8'($urandom_range(255));
    endfunction

    // header line plus up to three sequence lines
    task automatic send_record(input int hdr_len, input header_style_t style);
        int line_len;
        // long headers start from a clean line whatever came before
        if (style != HDR_PLAIN) send_item(CH_NL, 1'b0);
        send_item(CH_GT, 1'b0);
        for (int i = 1; i <= hdr_len; i++) begin
            if (style == HDR_PLAIN) begin
                send_item(header_byte(), 1'b0);
            end else if (style == HDR_LONG_LINE && i < 300) begin
                // separators first, so the name starts late; it then runs past
                // the name cap and into the line limit
                case ($urandom_range(2))
                    0: send_item(CH_SPACE, 1'b0);
                    1: send_item(CH_TAB, 1'b0);
                    default: send_item(CH_PIPE, 1'b0);
                endcase
            end else begin
                send_item(letter_byte(), 1'b0);
            end
        end
        send_item(CH_NL, 1'b0);
        repeat ($urandom_range(3)) begin
            line_len = $urandom_range(24);
            repeat (line_len) send_item(sequence_byte(), 1'b0);
            send_item(CH_NL, 1'b0);
        end
    endtask

    // mostly well-formed records, with end of input, junk lines and blanks
    task automatic random_stream(input int budget);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_item(8'($urandom_range(255)), 1'b1);
                if ($urandom_range(1)) begin
                    repeat ($urandom_range(8, 1)) send_item(8'($urandom_range(255)), 1'b0);
                    send_item(CH_NL, 1'b0);
                end
            end else if (pick < 18) begin
                repeat ($urandom_range(8, 1)) send_item(8'($urandom_range(255)), 1'b0);
                send_item(CH_NL, 1'b0);
            end else if (pick < 26) begin
                send_item(CH_NL, 1'b0);
            end else begin
                send_record($urandom_range(14), HDR_PLAIN);
            end
        end
    endtask

    initial begin : stimulus
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: offset zero, so the first '>' is a name character
        set_config(8'd0, 1'b0);
        send_text("\n");
        send_text("Q\n");
        send_text(">|x\n");
        send_text("tUcAgN.");
        send_item(8'hFF, 1'b0);
        send_text(">");
        send_text(" \t|Z:\n");
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b1);
        quiesce();

        // default offset, no idling
        set_config(8'd1, 1'b0);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        random_stream(75);
        quiesce();

        // largest offset, counting only, source gaps; one header whose name
        // runs past the length cap and the line limit
        set_config(8'd255, 1'b1);
        src_idle_pct   = 52;
        sink_stall_pct = 0;
        send_record(1030, HDR_LONG_LINE);
        random_stream(75);
        quiesce();

        // small offset, sink stalls
        set_config(8'($urandom_range(6, 2)), 1'b0);
        src_idle_pct   = 0;
        sink_stall_pct = 52;
        random_stream(75);
        quiesce();

        // offset zero, counting only, both sides idle
        set_config(8'd0, 1'b1);
        src_idle_pct   = 18;
        sink_stall_pct = 18;
        random_stream(75);
        quiesce();

        if (check_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- fasta_record_parser.f -----
rtl/frp_pkg.sv
rtl/frp_in_stage.sv
rtl/frp_core.sv
rtl/frp_out_stage.sv
rtl/fasta_record_parser.sv
rtl/frp_checker.sv
tb/sv/frp_result_checker.sv
tb/sv/tb_fasta_record_parser.sv
